// ===== rtl/core/pcl_pkg.sv =====
`default_nettype none
package pcl_pkg;

  // fixed field widths of the ports
  localparam int unsigned CMD_W = 3;
  localparam int unsigned POS_W = 7;
  localparam int unsigned VAL_W = 8;
  localparam int unsigned STS_W = 3;
  localparam int unsigned LEN_W = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 3'd0,
    CMD_GET    = 3'd1,
    CMD_LOCATE = 3'd2,
    CMD_INSERT = 3'd3,
    CMD_DELETE = 3'd4
  } cmd_t;

  typedef enum logic [STS_W-1:0] {
    ST_OK           = 3'd0,
    ST_NOT_FOUND    = 3'd1,
    ST_PREV_MISSING = 3'd2,
    ST_POS_MISSING  = 3'd3,
    ST_FULL         = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LAUNCH,
    S_SCAN
  } state_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_APPEND,
    OP_INSERT,
    OP_DELETE
  } cell_op_t;

  // broadcast control seen by every cell
  typedef struct packed {
    cell_op_t         op;
    logic             get;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] value;
  } cell_ctl_t;

  // query token handed from cell to cell
  typedef struct packed {
    logic             live;
    logic             hit;
    logic [VAL_W-1:0] val;
    logic [POS_W-1:0] pos;
  } qry_t;

endpackage
`default_nettype wire

// ===== rtl/core/pcl_cell.sv =====
`default_nettype none
module pcl_cell
  import pcl_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned I     = 0,
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cell_ctl_t        ctl,
  input  wire logic [CW-1:0]    idx,
  input  wire logic [CW-1:0]    cnt,
  input  wire logic [VAL_W-1:0] left_entry,
  input  wire logic [VAL_W-1:0] right_entry,
  input  wire qry_t             q_in,
  output logic [VAL_W-1:0]      entry,
  output qry_t                  q_out
);

  localparam logic [CW-1:0]    ME      = CW'(I);
  localparam logic [CW-1:0]    ME_NEXT = CW'(I + 1);
  localparam logic [POS_W-1:0] POSN    = POS_W'(I + 1);
  localparam bit               POSN_OK = (I + 1) < (1 << POS_W);

  logic [VAL_W-1:0] entry_r, entry_nxt;
  qry_t             q_r, q_nxt;
  logic             active;
  logic             match;

  assign active = ME < cnt;

  // entry update: hold, write, take from left or take from right
  always_comb begin
    entry_nxt = entry_r;
    case (ctl.op)
      OP_APPEND: begin
        if (ME == cnt) entry_nxt = ctl.value;
      end
      OP_INSERT: begin
        if (ME == idx) entry_nxt = ctl.value;
        else if (ME > idx && ME <= cnt) entry_nxt = left_entry;
      end
      OP_DELETE: begin
        if (ME >= idx && ME_NEXT < cnt) entry_nxt = right_entry;
      end
      default: entry_nxt = entry_r;
    endcase
  end

  // query token: first live hit wins, later cells pass it on
  always_comb begin
    if (ctl.get) match = POSN_OK && (ctl.pos == POSN);
    else         match = (entry_r == ctl.value);
    q_nxt = q_in;
    if (q_in.live && !q_in.hit && active && match) begin
      q_nxt.hit = 1'b1;
      q_nxt.val = entry_r;
      q_nxt.pos = POSN;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (!rst_n) begin
      q_r.live <= 1'b0;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign entry = entry_r;
  assign q_out = q_r;

endmodule
`default_nettype wire

// ===== rtl/core/positional_char_list.sv =====
`default_nettype none
// channel | dir | handshake          | word
// in      | in  | in_valid/in_ready  | cmd, position, value
// out     | out | out_valid/out_ready| status, found_value, found_position, length
//
// append, insert, delete and unknown codes: result registered the next cycle
// get and locate: result registered once the query token has walked the cell chain
// one word in flight; in_ready waits for the scan and for a free output register
// synchronous active-low reset clears the length and the query tokens, entries stay
// a stalled output holds its word and blocks the next input word
module positional_char_list
  import pcl_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [CMD_W-1:0] in_cmd,
  input  wire logic [POS_W-1:0] in_position,
  input  wire logic [VAL_W-1:0] in_value,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [STS_W-1:0]      out_status,
  output logic [VAL_W-1:0]      out_found_value,
  output logic [POS_W-1:0]      out_found_position,
  output logic [LEN_W-1:0]      out_length
);

  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

  state_t           state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             qget_r, qget_nxt;
  logic [POS_W-1:0] qpos_r, qpos_nxt;
  logic [VAL_W-1:0] qval_r, qval_nxt;
  logic             ovalid_r, ovalid_nxt;
  status_t          osts_r, osts_nxt;
  logic [VAL_W-1:0] ofv_r, ofv_nxt;
  logic [POS_W-1:0] ofp_r, ofp_nxt;

  logic             accept;
  logic             is_query;
  logic             full;
  logic [POS_W-1:0] idx_pos;
  logic [CMPW-1:0]  idx_ext;
  logic [CMPW-1:0]  cnt_ext;
  cell_op_t         op;
  cell_ctl_t        ctl;
  qry_t             q_w [DEPTH+1];
  qry_t             q_last;
  logic [VAL_W-1:0] entry_w [DEPTH];
  logic [VAL_W-1:0] left_w  [DEPTH];
  logic [VAL_W-1:0] right_w [DEPTH];

  assign in_ready = (state_r == S_IDLE) && (!ovalid_r || out_ready);
  assign accept   = in_valid && in_ready;
  assign is_query = (cmd_t'(in_cmd) == CMD_GET) || (cmd_t'(in_cmd) == CMD_LOCATE);
  assign full     = (cnt_r == CW'(DEPTH));
  assign idx_pos  = (in_position == '0) ? '0 : in_position - 1'b1;
  assign idx_ext  = CMPW'(idx_pos);
  assign cnt_ext  = CMPW'(cnt_r);
  assign q_last   = q_w[DEPTH];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (accept && is_query) state_nxt = S_LAUNCH;
      S_LAUNCH: state_nxt = S_SCAN;
      S_SCAN:   if (q_last.live) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // command decode, length update and result register
  always_comb begin
    op         = OP_HOLD;
    cnt_nxt    = cnt_r;
    qget_nxt   = qget_r;
    qpos_nxt   = qpos_r;
    qval_nxt   = qval_r;
    ovalid_nxt = ovalid_r && !out_ready;
    osts_nxt   = osts_r;
    ofv_nxt    = ofv_r;
    ofp_nxt    = ofp_r;
    if (accept) begin
      ovalid_nxt = 1'b1;
      ofv_nxt    = '0;
      ofp_nxt    = '0;
      osts_nxt   = ST_NOT_FOUND;
      unique case (cmd_t'(in_cmd))
        CMD_APPEND: begin
          if (full) begin
            osts_nxt = ST_FULL;
          end else begin
            op       = OP_APPEND;
            cnt_nxt  = cnt_r + 1'b1;
            osts_nxt = ST_OK;
          end
        end
        CMD_INSERT: begin
          if (full) begin
            osts_nxt = ST_FULL;
          end else if (idx_ext > cnt_ext) begin
            osts_nxt = ST_PREV_MISSING;
          end else begin
            op       = OP_INSERT;
            cnt_nxt  = cnt_r + 1'b1;
            osts_nxt = ST_OK;
          end
        end
        CMD_DELETE: begin
          if (idx_ext > cnt_ext) begin
            osts_nxt = ST_PREV_MISSING;
          end else if (idx_ext == cnt_ext) begin
            osts_nxt = ST_POS_MISSING;
          end else begin
            op       = OP_DELETE;
            cnt_nxt  = cnt_r - 1'b1;
            osts_nxt = ST_OK;
          end
        end
        CMD_GET, CMD_LOCATE: begin
          ovalid_nxt = 1'b0;
          qget_nxt   = (cmd_t'(in_cmd) == CMD_GET);
          qpos_nxt   = in_position;
          qval_nxt   = in_value;
        end
        default: osts_nxt = ST_NOT_FOUND;
      endcase
    end
    if (state_r == S_SCAN && q_last.live) begin
      ovalid_nxt = 1'b1;
      osts_nxt   = q_last.hit ? ST_OK : ST_NOT_FOUND;
      ofv_nxt    = q_last.hit ? q_last.val : '0;
      ofp_nxt    = q_last.hit ? q_last.pos : '0;
    end
  end

  // broadcast to the cells and launch of the query token
  always_comb begin
    ctl.op    = op;
    ctl.get   = qget_r;
    ctl.pos   = qpos_r;
    ctl.value = (state_r == S_IDLE) ? in_value : qval_r;
    q_w[0]      = '0;
    q_w[0].live = (state_r == S_LAUNCH);
  end

  // the cell chain
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left_w[g] = '0;
    end else begin : g_mid_l
      assign left_w[g] = entry_w[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w[g] = '0;
    end else begin : g_mid_r
      assign right_w[g] = entry_w[g+1];
    end
    pcl_cell #(
      .DEPTH (DEPTH),
      .I     (g)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .idx         (CW'(idx_pos)),
      .cnt         (cnt_r),
      .left_entry  (left_w[g]),
      .right_entry (right_w[g]),
      .q_in        (q_w[g]),
      .entry       (entry_w[g]),
      .q_out       (q_w[g+1])
    );
  end

  always_ff @(posedge clk) begin
    qget_r <= qget_nxt;
    qpos_r <= qpos_nxt;
    qval_r <= qval_nxt;
    osts_r <= osts_nxt;
    ofv_r  <= ofv_nxt;
    ofp_r  <= ofp_nxt;
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_valid          = ovalid_r;
  assign out_status         = osts_r;
  assign out_found_value    = ofv_r;
  assign out_found_position = ofp_r;
  assign out_length         = LEN_W'(cnt_r);

  // length never passes the capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("list length above capacity");

  // a finished scan always finds the output register free
  a_scan_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && q_last.live) |-> !ovalid_r)
    else $error("scan result would overwrite a pending word");

  // no token reaches the end of the chain outside a scan
  a_token_scan: assert property (@(posedge clk) disable iff (!rst_n)
    q_last.live |-> (state_r == S_SCAN))
    else $error("query token outside scan");

  // an accepted append on a list that is not full grows it by one
  a_append_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && cmd_t'(in_cmd) == CMD_APPEND && !full) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("append did not grow the list");

endmodule
`default_nettype wire

// ===== tb/tb_positional_char_list.sv =====
module tb_positional_char_list;
  import pcl_pkg::*;

  localparam int unsigned LIST_DEPTH = 64;
  localparam int unsigned SCAN_CYCLES = LIST_DEPTH + 2;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = 3'd5;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  typedef struct {
    status_t          status;
    logic [VAL_W-1:0] found_value;
    logic [POS_W-1:0] found_position;
    logic [LEN_W-1:0] length;
  } list_reply_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [CMD_W-1:0] in_cmd = '0;
  logic [POS_W-1:0] in_position = '0;
  logic [VAL_W-1:0] in_value = '0;
  logic             out_valid;
  logic             out_ready = 1'b1;
  logic [STS_W-1:0] out_status;
  logic [VAL_W-1:0] out_found_value;
  logic [POS_W-1:0] out_found_position;
  logic [LEN_W-1:0] out_length;

  // shadow copy of the list and the replies still owed by the block
  logic [VAL_W-1:0] shadow_list[$];
  list_reply_t      reply_q[$];

  int unsigned error_count;
  int unsigned word_count;
  int unsigned reply_count;
  int unsigned peak_length;
  int unsigned full_hits;
  int unsigned cmd_hits[8];
  int unsigned cycle_count;
  int unsigned stall_left;
  bit          gap_en;
  bit          stall_en;

  positional_char_list #(
    .DEPTH(LIST_DEPTH)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_position       (in_position),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_found_value   (out_found_value),
    .out_found_position(out_found_position),
    .out_length        (out_length)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // apply one word to the shadow list and return the reply it earns
  function automatic list_reply_t apply_list_word(input logic [CMD_W-1:0] cmd,
                                                  input logic [POS_W-1:0] pos,
                                                  input logic [VAL_W-1:0] val);
    list_reply_t r;
    int unsigned slot;
    int k;
    r.status = ST_NOT_FOUND;
    r.found_value = '0;
    r.found_position = '0;
    slot = (pos == 0) ? 0 : pos - 1;
    case (cmd)
      CMD_APPEND: begin
        if (shadow_list.size() >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_list.push_back(val);
          r.status = ST_OK;
        end
      end
      CMD_GET: begin
        if (pos != 0 && pos <= shadow_list.size()) begin
          r.status = ST_OK;
          r.found_value = shadow_list[pos-1];
          r.found_position = pos;
        end
      end
      CMD_LOCATE: begin
        // walk from the tail so the first match wins
        for (k = shadow_list.size() - 1; k >= 0; k--) begin
          if (shadow_list[k] == val) begin
            r.status = ST_OK;
            r.found_value = val;
            r.found_position = POS_W'(k + 1);
          end
        end
      end
      CMD_INSERT: begin
        if (shadow_list.size() >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else if (slot > shadow_list.size()) begin
          r.status = ST_PREV_MISSING;
        end else begin
          shadow_list.insert(slot, val);
          r.status = ST_OK;
        end
      end
      CMD_DELETE: begin
        if (slot > shadow_list.size()) begin
          r.status = ST_PREV_MISSING;
        end else if (slot == shadow_list.size()) begin
          r.status = ST_POS_MISSING;
        end else begin
          shadow_list.delete(slot);
          r.status = ST_OK;
        end
      end
      default: ;
    endcase
    r.length = LEN_W'(shadow_list.size());
    return r;
  endfunction

  // present one word, hold it until taken, then log the reply it owes
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                           input logic [VAL_W-1:0] val);
    list_reply_t r;
    if (gap_en && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_position <= pos;
    in_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = apply_list_word(cmd, pos, val);
    reply_q.push_back(r);
    word_count++;
    cmd_hits[cmd]++;
    if (r.status == ST_FULL) full_hits++;
    if (shadow_list.size() > peak_length) peak_length = shadow_list.size();
  endtask

  task automatic wait_replies_done();
    while (reply_q.size() != 0) @(posedge clk);
  endtask

  // random word shaped by the current length; grow_pct sets the share of edits that grow the list
  task automatic send_random_word(input int unsigned grow_pct);
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    int unsigned len;
    int unsigned roll;
    len = shadow_list.size();
    roll = $urandom_range(0, 99);
    // a narrow alphabet now and then makes duplicate bytes for locate
    val = ($urandom_range(0, 2) == 0) ? VAL_W'($urandom_range(0, 7)) : VAL_W'($urandom);
    pos = POS_W'($urandom);
    if (roll < 4) begin
      cmd = CMD_W'($urandom_range(CMD_FIRST_UNUSED, 2**CMD_W - 1));
    end else if (roll < 40) begin
      cmd = $urandom_range(0, 1) ? CMD_GET : CMD_LOCATE;
      if (len != 0 && $urandom_range(0, 9) != 0) begin
        pos = POS_W'($urandom_range(1, len));
        if (cmd == CMD_LOCATE) val = shadow_list[$urandom_range(0, len - 1)];
      end
    end else if ($urandom_range(0, 99) < grow_pct) begin
      cmd = $urandom_range(0, 1) ? CMD_APPEND : CMD_INSERT;
      if ($urandom_range(0, 9) != 0) pos = POS_W'($urandom_range(0, len + 1));
    end else begin
      cmd = CMD_DELETE;
      if ($urandom_range(0, 9) != 0) pos = POS_W'($urandom_range(0, len));
    end
    send_word(cmd, pos, val);
  endtask

  task automatic test_empty_list();
    int c;
    send_word(CMD_GET, '0, '0);
    send_word(CMD_GET, POS_W'(1), '0);
    send_word(CMD_LOCATE, '0, '0);
    // front of an empty list: position missing
    send_word(CMD_DELETE, '0, '0);
    send_word(CMD_DELETE, POS_W'(2), '0);
    send_word(CMD_INSERT, POS_W'(2), 8'h11);
    for (c = CMD_FIRST_UNUSED; c < 2**CMD_W; c++) send_word(CMD_W'(c), POS_MAX, '1);
  endtask

  task automatic test_small_list();
    send_word(CMD_APPEND, POS_MAX, 8'h00);
    send_word(CMD_APPEND, '0, 8'hFF);
    send_word(CMD_INSERT, '0, 8'hA5);
    // just past the tail is legal, one further is not
    send_word(CMD_INSERT, POS_W'(4), 8'h3C);
    send_word(CMD_INSERT, POS_W'(6), 8'h77);
    send_word(CMD_INSERT, POS_W'(2), 8'hFF);
    send_word(CMD_GET, POS_W'(1), '0);
    send_word(CMD_GET, POS_W'(5), '0);
    send_word(CMD_GET, POS_W'(6), '0);
    send_word(CMD_GET, POS_MAX, '0);
    // two copies of ff: the first one must be reported
    send_word(CMD_LOCATE, '0, 8'hFF);
    send_word(CMD_LOCATE, '0, 8'h5A);
    send_word(CMD_DELETE, POS_W'(5), '0);
    send_word(CMD_DELETE, POS_W'(5), '0);
    send_word(CMD_DELETE, POS_MAX, '0);
    send_word(CMD_DELETE, '0, '0);
  endtask

  task automatic test_balanced_mix(input int unsigned n);
    repeat (n) send_random_word(50);
  endtask

  task automatic test_fill_to_full();
    while (shadow_list.size() < LIST_DEPTH) send_random_word(90);
    send_word(CMD_APPEND, '0, 8'hFF);
    // full is flagged ahead of a bad position
    send_word(CMD_INSERT, POS_MAX, 8'h00);
    send_word(CMD_INSERT, '0, 8'h5A);
    send_word(CMD_GET, POS_W'(LIST_DEPTH), '0);
    send_word(CMD_DELETE, POS_W'(LIST_DEPTH + 1), '0);
    send_word(CMD_DELETE, POS_W'(LIST_DEPTH), '0);
    // hover around the full mark
    repeat (120) send_random_word(75);
  endtask

  task automatic test_pause_until_drained();
    repeat (60) send_random_word(50);
    in_valid <= 1'b0;
    wait_replies_done();
    repeat (60) send_random_word(50);
  endtask

  task automatic test_shrink_to_empty();
    repeat (200) send_random_word(20);
    while (shadow_list.size() != 0) send_random_word(5);
    repeat (20) send_random_word(30);
  endtask

  task automatic test_back_to_back(input int unsigned n);
    gap_en = 1'b0;
    stall_en <= 1'b0;
    repeat (n) send_random_word(55);
  endtask

  task automatic check_field(input string name, input logic [VAL_W-1:0] exp_v,
                             input logic [VAL_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  // compare every reply with the oldest one owed
  always @(posedge clk) begin : check_replies
    list_reply_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (reply_q.size() == 0) begin
        $display("%0t: reply with no word pending, status %0d length %0d",
                 $time, out_status, out_length);
        error_count++;
      end else begin
        exp_r = reply_q.pop_front();
        check_field("status", exp_r.status, out_status);
        check_field("found_value", exp_r.found_value, out_found_value);
        check_field("found_position", exp_r.found_position, out_found_position);
        check_field("length", exp_r.length, out_length);
        reply_count++;
      end
    end
  end

  // receiver stalls in bursts of random length
  always @(posedge clk) begin
    if (!stall_en) begin
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 18);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding", cycle_count,
               reply_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    gap_en = 1'b1;
    stall_en <= 1'b1;
    test_empty_list();
    test_small_list();
    test_balanced_mix(500);
    test_fill_to_full();
    test_pause_until_drained();
    test_shrink_to_empty();
    test_balanced_mix(450);
    test_back_to_back(350);
    in_valid <= 1'b0;
    wait_replies_done();
    repeat (SCAN_CYCLES + 4) @(posedge clk);
    $display("sent %0d words: %0d append, %0d get, %0d locate, %0d insert, %0d delete, %0d unused",
             word_count, cmd_hits[CMD_APPEND], cmd_hits[CMD_GET], cmd_hits[CMD_LOCATE],
             cmd_hits[CMD_INSERT], cmd_hits[CMD_DELETE],
             cmd_hits[5] + cmd_hits[6] + cmd_hits[7]);
    $display("checked %0d replies, peak length %0d, %0d full rejections, %0d errors",
             reply_count, peak_length, full_hits, error_count);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== positional_char_list.f =====
rtl/core/pcl_pkg.sv
rtl/core/pcl_cell.sv
rtl/core/positional_char_list.sv
tb/tb_positional_char_list.sv
